// ----- hdl/bsp_pkg.sv -----
// Shared types and constants for the binary search probe counter.
package bsp_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int INDEX_W     = 10;
  localparam int COUNT_W     = 11;
  localparam int DATA_W      = 32;
  localparam int PROBE_W     = 4;
  localparam logic [PROBE_W-1:0] PROBE_MAX = PROBE_W'(15);

  typedef enum logic {
    MODE_WRITE  = 1'b0,
    MODE_SEARCH = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t                     mode;
    logic [INDEX_W-1:0]        entry_index;
    logic signed [DATA_W-1:0]  entry_value;
    logic signed [DATA_W-1:0]  search_key;
  } in_t;

  typedef struct packed {
    logic [PROBE_W-1:0] probe_count;
    logic               key_found;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_DONE
  } seq_state_t;

  // Request side of the search sequencer.
  typedef struct packed {
    logic                     start;
    logic signed [DATA_W-1:0] key;
    logic [COUNT_W-1:0]       count;
    logic                     res_ready;
  } search_req_t;

  // Status side of the search sequencer.
  typedef struct packed {
    logic busy;
    logic done;
    out_t result;
  } search_rsp_t;

endpackage

// ----- hdl/binary_search_probe_counter_core.sv -----
// Top level: handshakes, entry count register, sorted table and search sequencer.
// Write transaction: table updated at the accepting edge.
// Search transaction: result registered from S_DONE; a hit goes there straight from the
//   compare, a miss first returns to S_READ to find the window empty; at most 11 probes with 1024 entries.
// Each probe is one table RAM read, then one compare.
// Next transaction accepted in the cycle after the result reaches the output register.
// Synchronous reset clears control state and entry_count; table contents stay undefined.
module binary_search_probe_counter_core (
  input  logic                         clk,
  input  logic                         rst,
  // input transactions
  input  logic                         in_valid,
  output logic                         in_stall,
  input  bsp_pkg::in_t                 in_data,
  // result transactions
  output logic                         out_valid,
  input  logic                         out_stall,
  output bsp_pkg::out_t                out_data,
  // entry_count register write
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bsp_pkg::COUNT_W-1:0]  cfg_data
);

  logic                         in_accept;
  logic                         tbl_we;
  logic [bsp_pkg::COUNT_W-1:0]  entry_count;
  logic [bsp_pkg::COUNT_W-1:0]  count_sat;
  logic                         rd_en;
  logic [bsp_pkg::ADDR_W-1:0]   rd_addr;
  logic [bsp_pkg::DATA_W-1:0]   rd_data;
  logic                         res_load;
  bsp_pkg::search_req_t         req;
  bsp_pkg::search_rsp_t         rsp;

  // Config writes are always taken; the user must send them only while idle, as the block never checks.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      entry_count <= cfg_data;
    end
  end

  // Clamp the live entry count to the table size.
  assign count_sat = (entry_count > bsp_pkg::COUNT_W'(bsp_pkg::TABLE_DEPTH))
                   ? bsp_pkg::COUNT_W'(bsp_pkg::TABLE_DEPTH) : entry_count;

  // Hold off new transactions while a search is in flight or waiting to unload.
  assign in_stall  = rsp.busy;
  assign in_accept = in_valid && !in_stall;

  // Write transactions go straight into the table; drop indexes past the end.
  assign tbl_we = in_accept && (in_data.mode == bsp_pkg::MODE_WRITE)
               && (bsp_pkg::COUNT_W'(in_data.entry_index)
                   < bsp_pkg::COUNT_W'(bsp_pkg::TABLE_DEPTH));

  bsp_ram #(
    .WIDTH (bsp_pkg::DATA_W),
    .DEPTH (bsp_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (in_data.entry_index[bsp_pkg::ADDR_W-1:0]),
    .wdata (in_data.entry_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Output register is free when empty or being drained this cycle.
  assign res_load = rsp.done && (!out_valid || !out_stall);

  assign req.start     = in_accept && (in_data.mode == bsp_pkg::MODE_SEARCH);
  assign req.key       = in_data.search_key;
  assign req.count     = count_sat;
  assign req.res_ready = !out_valid || !out_stall;

  bsp_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Result register: load a finished search, hold while stalled, clear once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data <= rsp.result;
    end
  end

endmodule

// ----- hdl/bsp_ram.sv -----
// Generic single-clock RAM, one write port, one registered read port.
module bsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/bsp_seq.sv -----
// Binary search sequencer: one table read and one compare per probe.
module bsp_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  bsp_pkg::search_req_t           req,
  output bsp_pkg::search_rsp_t           rsp,
  output logic                           rd_en,
  output logic [bsp_pkg::ADDR_W-1:0]     rd_addr,
  input  logic [bsp_pkg::DATA_W-1:0]     rd_data
);

  bsp_pkg::seq_state_t state, state_next;

  logic signed [bsp_pkg::DATA_W-1:0] key, key_next;
  logic [bsp_pkg::COUNT_W-1:0]       lo, lo_next;
  logic [bsp_pkg::COUNT_W-1:0]       hi_x, hi_x_next;   // exclusive upper bound
  logic [bsp_pkg::COUNT_W-1:0]       mid, mid_next;
  logic [bsp_pkg::COUNT_W-1:0]       mid_calc;
  logic [bsp_pkg::PROBE_W-1:0]       probes, probes_next;
  logic                              found, found_next;
  logic                              span_open;
  logic signed [bsp_pkg::DATA_W-1:0] entry;

  assign span_open = lo < hi_x;
  assign mid_calc  = lo + ((hi_x - lo - bsp_pkg::COUNT_W'(1)) >> 1);
  assign entry     = $signed(rd_data);

  assign rd_en   = (state == bsp_pkg::S_READ) && span_open;
  assign rd_addr = mid_calc[bsp_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= bsp_pkg::S_IDLE;
      lo     <= '0;
      hi_x   <= '0;
      probes <= '0;
      found  <= 1'b0;
    end else begin
      state  <= state_next;
      lo     <= lo_next;
      hi_x   <= hi_x_next;
      probes <= probes_next;
      found  <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
    mid <= mid_next;
  end

  always_comb begin
    state_next  = state;
    key_next    = key;
    lo_next     = lo;
    hi_x_next   = hi_x;
    mid_next    = mid;
    probes_next = probes;
    found_next  = found;
    case (state)
      bsp_pkg::S_IDLE: begin
        if (req.start) begin
          key_next    = req.key;
          lo_next     = '0;
          hi_x_next   = req.count;
          probes_next = '0;
          found_next  = 1'b0;
          state_next  = bsp_pkg::S_READ;
        end
      end
      bsp_pkg::S_READ: begin
        if (span_open) begin
          mid_next   = mid_calc;
          state_next = bsp_pkg::S_CMP;
        end else begin
          state_next = bsp_pkg::S_DONE;
        end
      end
      bsp_pkg::S_CMP: begin
        if (probes != bsp_pkg::PROBE_MAX) begin
          probes_next = probes + bsp_pkg::PROBE_W'(1);
        end
        if (key == entry) begin
          found_next = 1'b1;
          state_next = bsp_pkg::S_DONE;
        end else if (key < entry) begin
          hi_x_next  = mid;
          state_next = bsp_pkg::S_READ;
        end else begin
          lo_next    = mid + bsp_pkg::COUNT_W'(1);
          state_next = bsp_pkg::S_READ;
        end
      end
      bsp_pkg::S_DONE: begin
        if (req.res_ready) begin
          state_next = bsp_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bsp_pkg::S_IDLE;
      end
    endcase
  end

  assign rsp.busy               = state != bsp_pkg::S_IDLE;
  assign rsp.done               = state == bsp_pkg::S_DONE;
  assign rsp.result.probe_count = probes;
  assign rsp.result.key_found   = found;

  // A compare always follows the read that fetched its entry.
  a_cmp_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == bsp_pkg::S_CMP) |-> $past(state == bsp_pkg::S_READ))
    else $error("compare without a preceding read");

  // The search window never inverts and never leaves the table.
  a_window: assert property (@(posedge clk) disable iff (rst)
    (state == bsp_pkg::S_READ) |->
      (lo <= hi_x) && (hi_x <= bsp_pkg::COUNT_W'(bsp_pkg::TABLE_DEPTH)))
    else $error("search window out of range");

  // A hit needs at least one probe.
  a_hit_probed: assert property (@(posedge clk) disable iff (rst)
    (state == bsp_pkg::S_DONE && found) |-> (probes != '0))
    else $error("hit reported with no probe");

  // The probed address lies inside the live window.
  a_probe_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == bsp_pkg::S_CMP) |-> (mid >= lo) && (mid < hi_x))
    else $error("probe outside window");

endmodule
